>>> sv/tdp_pkg.sv
`default_nettype none
package tdp_pkg;

    // width of the tested value and derived widths
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int SQ_W        = VALUE_WIDTH + 1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_LOOP,
        ST_WAIT,
        ST_RESULT
    } tdp_state_t;

    // status from the remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rem_status_t;

endpackage
`default_nettype wire

>>> sv/tdp_rem_unit.sv
`default_nettype none
module tdp_rem_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [tdp_pkg::VALUE_WIDTH-1:0]   dividend,
    input  wire logic [tdp_pkg::VALUE_WIDTH-1:0]   divisor,
    output tdp_pkg::rem_status_t                   status
);
    import tdp_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] dvd_reg;
    logic [VALUE_WIDTH-1:0] dsr_reg;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic [VALUE_WIDTH-1:0] rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[VALUE_WIDTH-1:0];
        end
        else
        begin
            rem_next = trial[VALUE_WIDTH-1:0];
        end
    end

    // control: bit counter, busy and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(VALUE_WIDTH - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: partial remainder and dividend shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule
`default_nettype wire

>>> sv/trial_division_prime_test.sv
`default_nettype none
// from input transfer, the sequencer passes through classify and then result for magnitudes
// below 4 or even; otherwise each odd divisor tried takes a loop check and a bit-serial
// remainder run, with one extra loop check ending the search when no divisor divides
// throughput: one item at a time, set by the bit-serial remainder unit and divisor loop
// the next item is taken while a finished result waits at the output register
// reset clears the sequencer and output valid; the payload registers are not reset
module trial_division_prime_test (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [tdp_pkg::VALUE_WIDTH-1:0] value,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic                                        is_prime
);
    import tdp_pkg::*;

    tdp_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic                   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   is_prime_reg, is_prime_next;
    logic                   rem_start;
    rem_status_t            rem_status;
    logic [SQ_W+1:0]        sq_sum;
    logic [VALUE_WIDTH-1:0] value_u;

    tdp_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (mag_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    assign value_u = value;
    // (d+2)^2 = d^2 + 4d + 4
    assign sq_sum  = {2'b00, sq_reg} + {1'b0, d_reg, 2'b00} + (SQ_W+2)'(4);

    // sequencer: classify, then step odd divisors while d*d <= m
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        rem_start      = 1'b0;
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (value_u[VALUE_WIDTH-1])
                    begin
                        mag_next = ~value_u + 1'b1;
                    end
                    else
                    begin
                        mag_next = value_u;
                    end
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                d_next  = VALUE_WIDTH'(3);
                sq_next = SQ_W'(9);
                if (mag_reg[VALUE_WIDTH-1:1] == '0)
                begin
                    res_next   = 1'b0;
                    state_next = ST_RESULT;
                end
                else if (mag_reg[VALUE_WIDTH-1:2] == '0)
                begin
                    res_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (!mag_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (sq_reg > {1'b0, mag_reg})
                begin
                    res_next   = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.rem_zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        d_next     = d_reg + VALUE_WIDTH'(2);
                        sq_next    = sq_sum[SQ_W-1:0];
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_RESULT:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        d_reg        <= d_next;
        sq_reg       <= sq_next;
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule
`default_nettype wire
